/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers of the core folder, included by triangle_classify_area
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// property checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed: invariant");

`endif

/* rtl/core/tca_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tca_pkg
// widths, kind codes and stage payload types of the triangle classifier
// ----------------------------------------------------------------------------
package tca_pkg;

  // side length width, 4 to 12
  localparam int SIDE_WIDTH = 12;

  // derived arithmetic widths
  localparam int SUM_W  = SIDE_WIDTH + 2;        // a+b+c
  localparam int PAIR_W = SIDE_WIDTH + 1;        // sum of two sides
  localparam int DIF_W  = SIDE_WIDTH + 1;        // e.g. b+c-a
  localparam int P1_W   = SUM_W + DIF_W;
  localparam int P2_W   = 2 * DIF_W;
  localparam int PROD_W = P1_W + P2_W;
  localparam int ROOT_W = (PROD_W + 1) / 2;      // one root bit per stage
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 1;
  localparam int AREA_W = 25;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_EQUI = 2'd1,
    KIND_ISO  = 2'd2,
    KIND_SCAL = 2'd3
  } kind_t;

  // after classification: sum and the three differences
  typedef struct packed {
    kind_t              kind;
    logic [SUM_W-1:0]   s;
    logic [DIF_W-1:0]   d1;
    logic [DIF_W-1:0]   d2;
    logic [DIF_W-1:0]   d3;
  } cls_t;

  // after the multiplier stages
  typedef struct packed {
    kind_t              kind;
    logic [PROD_W-1:0]  prod;
  } mul_t;

  // square root pipeline state
  typedef struct packed {
    kind_t              kind;
    logic [RAD_W-1:0]   rad;
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
  } rt_t;

endpackage

/* rtl/core/tca_classify.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tca_classify
// first stage: triangle test, kind, perimeter sum and side differences
// ----------------------------------------------------------------------------
module tca_classify (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [tca_pkg::SIDE_WIDTH-1:0] side_a,
  input  logic [tca_pkg::SIDE_WIDTH-1:0] side_b,
  input  logic [tca_pkg::SIDE_WIDTH-1:0] side_c,
  output logic                           ready,
  input  logic                           nxt_ready,
  output logic                           valid,
  output tca_pkg::cls_t                  data
);

  logic [tca_pkg::PAIR_W-1:0] ab;
  logic [tca_pkg::PAIR_W-1:0] ac;
  logic [tca_pkg::PAIR_W-1:0] bc;
  logic                       ok;
  tca_pkg::cls_t              data_next;

  // pair sums and the strict inequality test
  always_comb begin
    ab = tca_pkg::PAIR_W'(side_a) + tca_pkg::PAIR_W'(side_b);
    ac = tca_pkg::PAIR_W'(side_a) + tca_pkg::PAIR_W'(side_c);
    bc = tca_pkg::PAIR_W'(side_b) + tca_pkg::PAIR_W'(side_c);
    ok = (side_a != '0) && (side_b != '0) && (side_c != '0) &&
         (ab > tca_pkg::PAIR_W'(side_c)) && (ac > tca_pkg::PAIR_W'(side_b)) &&
         (bc > tca_pkg::PAIR_W'(side_a));
  end

  // kind and product factors, factors zeroed for a non-triangle
  always_comb begin
    data_next = '0;
    data_next.kind = tca_pkg::KIND_NONE;
    if (ok) begin
      if (side_a == side_b && side_b == side_c) begin
        data_next.kind = tca_pkg::KIND_EQUI;
      end else if (side_a == side_b || side_b == side_c || side_a == side_c) begin
        data_next.kind = tca_pkg::KIND_ISO;
      end else begin
        data_next.kind = tca_pkg::KIND_SCAL;
      end
      data_next.s  = tca_pkg::SUM_W'(ab) + tca_pkg::SUM_W'(side_c);
      data_next.d1 = bc - tca_pkg::DIF_W'(side_a);
      data_next.d2 = ac - tca_pkg::DIF_W'(side_b);
      data_next.d3 = ab - tca_pkg::DIF_W'(side_c);
    end
  end

  assign ready = !valid || nxt_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      data <= data_next;
    end
  end

endmodule

/* rtl/core/tca_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tca_mul
// two multiplier stages: pair products, then the full Heron product
// ----------------------------------------------------------------------------
module tca_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  tca_pkg::cls_t in_data,
  output logic          ready,
  input  logic          nxt_ready,
  output logic          valid,
  output tca_pkg::mul_t data
);

  logic                      v2;
  logic                      ready3;
  tca_pkg::kind_t            kind2;
  logic [tca_pkg::P1_W-1:0]  p1;
  logic [tca_pkg::P2_W-1:0]  p2;

  assign ready  = !v2 || ready3;
  assign ready3 = !valid || nxt_ready;

  // stage 2 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready) begin
      v2 <= in_valid;
    end
  end

  // stage 2: sum times one difference, product of the other two
  always_ff @(posedge clk) begin
    if (ready) begin
      kind2 <= in_data.kind;
      p1    <= tca_pkg::P1_W'(in_data.s) * tca_pkg::P1_W'(in_data.d1);
      p2    <= tca_pkg::P2_W'(in_data.d2) * tca_pkg::P2_W'(in_data.d3);
    end
  end

  // stage 3 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready3) begin
      valid <= v2;
    end
  end

  // stage 3: full product under the root
  always_ff @(posedge clk) begin
    if (ready3) begin
      data.kind <= kind2;
      data.prod <= tca_pkg::PROD_W'(p1) * tca_pkg::PROD_W'(p2);
    end
  end

endmodule

/* rtl/core/tca_root_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tca_root_step
// one registered stage of the digit-by-digit square root, one root bit
// ----------------------------------------------------------------------------
module tca_root_step (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  tca_pkg::rt_t in_data,
  output logic         ready,
  input  logic         nxt_ready,
  output logic         valid,
  output tca_pkg::rt_t data
);

  logic [tca_pkg::REM_W+1:0] rem2;
  logic [tca_pkg::REM_W+1:0] trial;
  logic [tca_pkg::REM_W+1:0] diff;
  logic                      take;
  tca_pkg::rt_t              data_next;

  // bring in two radicand bits, try root bit one
  always_comb begin
    rem2  = {in_data.rem, in_data.rad[tca_pkg::RAD_W-1 -: 2]};
    trial = (tca_pkg::REM_W + 2)'({in_data.root, 2'b01});
    diff  = rem2 - trial;
    take  = (rem2 >= trial);
    data_next.kind = in_data.kind;
    data_next.rad  = {in_data.rad[tca_pkg::RAD_W-3:0], 2'b00};
    data_next.rem  = take ? tca_pkg::REM_W'(diff) : tca_pkg::REM_W'(rem2);
    data_next.root = {in_data.root[tca_pkg::ROOT_W-2:0], take};
  end

  assign ready = !valid || nxt_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      data <= data_next;
    end
  end

endmodule

/* rtl/core/triangle_classify_area.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_classify_area
// triangle test, kind and floor of four times the Heron area, fully pipelined
//
//   channel | direction | handshake            | payload
//   tri     | in        | tri_valid, tri_stall | side_a, side_b, side_c
//   res     | out       | res_valid, res_stall | kind, area_quarters
//
// one triangle per cycle while res_stall is low; the pipeline is made of a
// classify stage, two multiplier stages and one square root stage per root bit.
// every stage holds while the stage after it is full and stalled; empty stages
// still fill, so tri_stall rises only when the whole pipeline is backed up.
// rst (synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_classify_area (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             tri_valid,
  output logic                             tri_stall,
  input  logic [tca_pkg::SIDE_WIDTH-1:0]   side_a,
  input  logic [tca_pkg::SIDE_WIDTH-1:0]   side_b,
  input  logic [tca_pkg::SIDE_WIDTH-1:0]   side_c,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic [1:0]                       kind,
  output logic [tca_pkg::AREA_W-1:0]       area_quarters
);

  localparam int NSTEP = tca_pkg::ROOT_W;

  logic          cls_ready;
  logic          cls_valid;
  tca_pkg::cls_t cls_data;
  logic          mul_ready;
  logic          mul_valid;
  tca_pkg::mul_t mul_data;

  logic          rt_valid [NSTEP+1];
  logic          rt_ready [NSTEP+1];
  tca_pkg::rt_t  rt_data  [NSTEP+1];

  // classification stage
  tca_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tri_valid),
    .side_a    (side_a),
    .side_b    (side_b),
    .side_c    (side_c),
    .ready     (cls_ready),
    .nxt_ready (mul_ready),
    .valid     (cls_valid),
    .data      (cls_data)
  );

  assign tri_stall = !cls_ready;

  // product stages
  tca_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cls_valid),
    .in_data   (cls_data),
    .ready     (mul_ready),
    .nxt_ready (rt_ready[0]),
    .valid     (mul_valid),
    .data      (mul_data)
  );

  // seed of the root pipeline
  always_comb begin
    rt_valid[0]     = mul_valid;
    rt_data[0].kind = mul_data.kind;
    rt_data[0].rad  = tca_pkg::RAD_W'(mul_data.prod);
    rt_data[0].rem  = '0;
    rt_data[0].root = '0;
  end

  // square root, one stage per result bit
  for (genvar i = 0; i < NSTEP; i++) begin : g_root
    tca_root_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (rt_valid[i]),
      .in_data   (rt_data[i]),
      .ready     (rt_ready[i]),
      .nxt_ready (rt_ready[i+1]),
      .valid     (rt_valid[i+1]),
      .data      (rt_data[i+1])
    );
  end

  // last root stage is the output register
  assign rt_ready[NSTEP] = !res_stall;
  assign res_valid       = rt_valid[NSTEP];
  assign kind            = rt_data[NSTEP].kind;
  assign area_quarters   = tca_pkg::AREA_W'(rt_data[NSTEP].root);

  // a proper triangle always has a nonzero area, a non-triangle has none
  `ASSERT_IMPL(a_kind_area, clk, rst, res_valid,
    (kind == tca_pkg::KIND_NONE) == (area_quarters == '0))
  // an empty output stage never backs up the input
  `ASSERT_IMPL(a_no_false_stall, clk, rst, !res_valid, !tri_stall)
  // reset empties the pipeline
  `ASSERT_IMPL(a_reset_empty, clk, rst, $past(rst), !res_valid)

endmodule
